// File: design/lppr_pkg.sv
// Shared types and constants for the length-prefixed packet reassembler.
`default_nettype none

package lppr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 4;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CLEN_W     = 13;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned M_TUSER_W  = 4;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;
  localparam logic [LEN_W-1:0] LEN_MASK      = 16'h7FFF;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_STORED     = 4'd0,
    STATUS_DROPPED    = 4'd1,
    STATUS_SHORT      = 4'd2,
    STATUS_INCOMPLETE = 4'd3,
    STATUS_CORRUPT    = 4'd4,
    STATUS_READY      = 4'd5,
    STATUS_BUSY       = 4'd6,
    STATUS_BYTE       = 4'd7,
    STATUS_EMPTY      = 4'd8
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN  = 1'b0,
    CFG_LEN_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_RD_DATA  = 3'd1,
    ST_POP_LO   = 3'd2,
    ST_POP_HI   = 3'd3,
    ST_POP_EVAL = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic push;
    logic clear;
    logic read_none;
    logic res_busy;
    logic res_short;
    logic rd_next;
    logic read_out;
    logic latch_lo;
    logic latch_len;
    logic pop_eval;
  } dp_cmd_t;

  typedef struct packed {
    logic res_block;
    logic read_busy;
    logic can_read;
    logic held_short;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/lppr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lppr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/lppr_ctrl.sv
// Sequencing controller: decodes transfers and steps header fetch and byte reads.
`default_nettype none

module lppr_ctrl import lppr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire kind_e    in_kind_i,
  input  wire dp_stat_t stat_i,
  output logic          in_ready_o,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        fire;

  assign in_ready_o = (state_q == ST_IDLE) && !stat_i.res_block;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          unique case (in_kind_i)
            KIND_READ: begin
              if (stat_i.can_read) state_d = ST_RD_DATA;
            end
            KIND_POP: begin
              if (!stat_i.read_busy && !stat_i.held_short) state_d = ST_POP_LO;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_DATA:  state_d = ST_IDLE;
      ST_POP_LO:   state_d = ST_POP_HI;
      ST_POP_HI:   state_d = ST_POP_EVAL;
      ST_POP_EVAL: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          unique case (in_kind_i)
            KIND_PUSH:  cmd_o.push  = 1'b1;
            KIND_CLEAR: cmd_o.clear = 1'b1;
            KIND_READ:  cmd_o.read_none = !stat_i.can_read;
            KIND_POP: begin
              cmd_o.res_busy  = stat_i.read_busy;
              cmd_o.res_short = !stat_i.read_busy && stat_i.held_short;
            end
            default: cmd_o = '0;
          endcase
        end
      end
      ST_RD_DATA: cmd_o.read_out = 1'b1;
      ST_POP_LO: begin
        cmd_o.latch_lo = 1'b1;
        cmd_o.rd_next  = 1'b1;
      end
      ST_POP_HI:   cmd_o.latch_len = 1'b1;
      ST_POP_EVAL: cmd_o.pop_eval  = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: design/lppr_dp.sv
// Datapath: ring pointers, counters, config registers, ring RAM and result stages.
`default_nettype none

module lppr_dp import lppr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [DATA_W-1:0]     in_byte_i,
  input  wire logic                  in_start_i,
  input  wire logic [CLEN_W-1:0]     in_clen_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_stat_t                   stat_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [STATUS_W-1:0]        out_status_o,
  output logic [LEN_W-1:0]           out_plen_o,
  output logic [DATA_W-1:0]          out_data_o,
  output logic                       out_last_o
);

  localparam int unsigned AW    = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SUM_W = ((CNT_W > CLEN_W) ? CNT_W : CLEN_W) + 1;
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(BUFFER_BYTES - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [LEN_W-1:0]  max_len_q;
  logic              mode_q;

  logic [AW-1:0]     front_q, front_d, rear_q, rear_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [CLEN_W-1:0] chunk_rem_q, chunk_rem_d;
  logic              chunk_acc_q, chunk_acc_d;
  logic [LEN_W-1:0]  read_rem_q, read_rem_d;
  logic [DATA_W-1:0] lo_q, lo_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic              res_valid_q, res_valid_d, res_load;
  status_e           res_status_q, res_status_d;
  logic [LEN_W-1:0]  res_plen_q, res_plen_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              res_last_q, res_last_d;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              fits, acc_eff, has_room, len_gt_held, len_gt_max;
  logic [CLEN_W-1:0] rem_eff, rem_new;
  logic [LEN_W-1:0]  raw_len, dec_len;

  assign out_free = !out_valid_o || out_ready_i;

  assign stat_o.res_block  = res_valid_q && !out_free;
  assign stat_o.read_busy  = read_rem_q != '0;
  assign stat_o.can_read   = (read_rem_q != '0) && (held_q != '0);
  assign stat_o.held_short = held_q < CNT_W'(HEADER_BYTES);

  assign fits     = (SUM_W'(held_q) + SUM_W'(in_clen_i)) <= SUM_W'(BUFFER_BYTES);
  assign acc_eff  = in_start_i ? ((in_clen_i != '0) && fits) : chunk_acc_q;
  assign rem_eff  = in_start_i ? in_clen_i : chunk_rem_q;
  assign rem_new  = rem_eff - CLEN_W'(1);
  assign has_room = held_q < CNT_W'(BUFFER_BYTES);

  assign raw_len = {ram_rdata, lo_q};
  assign dec_len = mode_q ? ((raw_len & LEN_MASK) + LEN_W'(HEADER_BYTES)) : raw_len;

  assign len_gt_held = CMP_W'(len_q) > CMP_W'(held_q);
  assign len_gt_max  = len_q > max_len_q;

  assign ram_raddr = cmd_i.rd_next ? ring_next(front_q) : front_q;

  lppr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rear_q),
    .wdata_i (in_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    front_d      = front_q;
    rear_d       = rear_q;
    held_d       = held_q;
    chunk_rem_d  = chunk_rem_q;
    chunk_acc_d  = chunk_acc_q;
    read_rem_d   = read_rem_q;
    lo_d         = lo_q;
    len_d        = len_q;
    ram_we       = 1'b0;
    res_load     = 1'b0;
    res_status_d = STATUS_EMPTY;
    res_plen_d   = '0;
    res_data_d   = '0;
    res_last_d   = 1'b0;

    if (cmd_i.push) begin
      res_load = 1'b1;
      if (rem_eff == '0) begin
        chunk_rem_d  = rem_eff;
        chunk_acc_d  = acc_eff;
        res_status_d = STATUS_DROPPED;
      end else begin
        chunk_rem_d = rem_new;
        chunk_acc_d = (rem_new == '0) ? 1'b0 : acc_eff;
        if (acc_eff && has_room) begin
          ram_we       = 1'b1;
          rear_d       = ring_next(rear_q);
          held_d       = held_q + CNT_W'(1);
          res_status_d = STATUS_STORED;
        end else begin
          res_status_d = STATUS_DROPPED;
        end
      end
    end else if (cmd_i.clear) begin
      front_d     = '0;
      rear_d      = '0;
      held_d      = '0;
      chunk_rem_d = '0;
      chunk_acc_d = 1'b0;
      read_rem_d  = '0;
      res_load    = 1'b1;
    end else if (cmd_i.read_none) begin
      read_rem_d = '0;
      res_load   = 1'b1;
    end else if (cmd_i.res_busy) begin
      res_load     = 1'b1;
      res_status_d = STATUS_BUSY;
    end else if (cmd_i.res_short) begin
      res_load     = 1'b1;
      res_status_d = STATUS_SHORT;
    end else if (cmd_i.latch_lo) begin
      lo_d = ram_rdata;
    end else if (cmd_i.latch_len) begin
      len_d = dec_len;
    end else if (cmd_i.read_out) begin
      front_d      = ring_next(front_q);
      held_d       = held_q - CNT_W'(1);
      read_rem_d   = read_rem_q - LEN_W'(1);
      res_load     = 1'b1;
      res_status_d = STATUS_BYTE;
      res_data_d   = ram_rdata;
      res_last_d   = read_rem_q == LEN_W'(1);
    end else if (cmd_i.pop_eval) begin
      res_load = 1'b1;
      if (len_q == '0) begin
        res_status_d = STATUS_SHORT;
      end else if (len_gt_held) begin
        res_status_d = STATUS_INCOMPLETE;
        res_plen_d   = len_q;
      end else if (len_gt_max) begin
        front_d      = '0;
        rear_d       = '0;
        held_d       = '0;
        chunk_rem_d  = '0;
        chunk_acc_d  = 1'b0;
        read_rem_d   = '0;
        res_status_d = STATUS_CORRUPT;
        res_plen_d   = len_q;
      end else begin
        read_rem_d   = len_q;
        res_status_d = STATUS_READY;
        res_plen_d   = len_q;
      end
    end

    res_valid_d = res_load || (res_valid_q && !out_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_LEN:  max_len_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_LEN_MODE: mode_q    <= cfg_wdata_i[0];
        default:      mode_q    <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      rear_q      <= '0;
      held_q      <= '0;
      chunk_rem_q <= '0;
      chunk_acc_q <= 1'b0;
      read_rem_q  <= '0;
      res_valid_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      front_q     <= front_d;
      rear_q      <= rear_d;
      held_q      <= held_d;
      chunk_rem_q <= chunk_rem_d;
      chunk_acc_q <= chunk_acc_d;
      read_rem_q  <= read_rem_d;
      res_valid_q <= res_valid_d;
      if (out_free) begin
        out_valid_o <= res_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    len_q <= len_d;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_plen_q   <= res_plen_d;
      res_data_q   <= res_data_d;
      res_last_q   <= res_last_d;
    end
    if (out_free && res_valid_q) begin
      out_status_o <= res_status_q;
      out_plen_o   <= res_plen_q;
      out_data_o   <= res_data_q;
      out_last_o   <= res_last_q;
    end
  end

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(BUFFER_BYTES))
    else $error("held count above ring size");

  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || out_free))
    else $error("result stage overwritten while stalled");

  a_chunk_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_acc_q |-> (chunk_rem_q != '0))
    else $error("accepted chunk with no bytes remaining");

endmodule

`default_nettype wire

// File: design/length_prefixed_packet_reassembler.sv
// Push, clear, busy, too-short and empty results pass the result stage and output register.
// A packet byte read first passes state ST_RD_DATA; a header pop passes ST_POP_LO, ST_POP_HI
// and ST_POP_EVAL (two length bytes come over the single read port one per cycle, then check).
// Push/clear: 1 transfer per cycle unless the output stalls; read and pop block until done.
// Reset: async active low clears pointers, counts and open chunk/packet; config returns to
// max_packet_length 4096, length_mode 0. Ring contents are not cleared.
`default_nettype none

module length_prefixed_packet_reassembler import lppr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // data_byte, chunk_start, chunk_length
  input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,   // kind
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,   // packet_length, data_out
  output logic [M_TUSER_W-1:0]       m_axis_tuser,   // status
  output logic                       m_axis_tlast
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [LEN_W-1:0]  out_plen;
  logic [DATA_W-1:0] out_data;

  lppr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (kind_e'(s_axis_tuser)),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  lppr_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_byte_i    (s_axis_tdata[DATA_W-1:0]),
    .in_start_i   (s_axis_tdata[DATA_W]),
    .in_clen_i    (s_axis_tdata[DATA_W+CLEN_W:DATA_W+1]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_plen_o   (out_plen),
    .out_data_o   (out_data),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_data, out_plen};

endmodule

`default_nettype wire
